>>> src/qxwm_pkg.sv
// ----------------------------------------------------------------------------
// qxwm_pkg: shared types and constants for the quad X wrench mixer
// Field widths, register indexes, reset values, pipeline enables and the
// signed 32-bit saturation used by the torque and output stages.
// ----------------------------------------------------------------------------
`default_nettype none

package qxwm_pkg;

  localparam int NUM_MOTORS = 4;

  localparam int CMD_W   = 16;
  localparam int QUAT_W  = 16;
  localparam int VEL_W   = 24;
  localparam int CFG_W   = 24;
  localparam int OUT_W   = 32;
  localparam int IDX_W   = 8;

  // Per-motor thrust and reaction torque, Q.16, never above the register value.
  localparam int MOTOR_W = 24;
  // Total thrust of four motors.
  localparam int TOTAL_W = 26;
  // Roll, pitch and yaw sums, signed.
  localparam int MIX_W   = 27;
  // Rotation matrix entry, signed Q.24.
  localparam int MAT_W   = 30;
  // Drag term, signed Q.16.
  localparam int DRAG_W  = 41;

  localparam int unsigned CMD_ONE       = 16384;
  localparam int unsigned SQRT_HALF_Q16 = 46341;

  localparam logic [IDX_W-1:0] REG_MAX_THRUST    = 8'd0;
  localparam logic [IDX_W-1:0] REG_MAX_REACT     = 8'd1;
  localparam logic [IDX_W-1:0] REG_ARM_LENGTH    = 8'd2;
  localparam logic [IDX_W-1:0] REG_DRAG_COEFF    = 8'd3;

  localparam logic [CFG_W-1:0] RST_MAX_THRUST    = 24'd273905;
  localparam logic [CFG_W-1:0] RST_MAX_REACT     = 24'd3641;
  localparam logic [CFG_W-1:0] RST_ARM_LENGTH    = 24'd14909;
  localparam logic [CFG_W-1:0] RST_DRAG_COEFF    = 24'd78643;

  typedef logic signed [MAT_W-1:0] mat_elem_t;
  typedef logic signed [OUT_W-1:0] word_t;

  // Load enables of the five pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

  function automatic word_t sat32(input logic signed [63:0] v);
    word_t res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> src/qxwm_lane.sv
// ----------------------------------------------------------------------------
// qxwm_lane: one motor lane
// Clamps the command to 0..1 (zero when the drive is disabled) and scales it
// to thrust and reaction torque with rounding. Registered at stage one.
// ----------------------------------------------------------------------------
`default_nettype none

module qxwm_lane (
  input  wire logic                                clk,
  input  wire qxwm_pkg::pipe_en_t                  pipe_en,
  input  wire logic signed [qxwm_pkg::CMD_W-1:0]   motor_cmd,
  input  wire logic                                drive_enable,
  input  wire logic [qxwm_pkg::CFG_W-1:0]          max_thrust,
  input  wire logic [qxwm_pkg::CFG_W-1:0]          max_reaction_torque,
  output logic [qxwm_pkg::MOTOR_W-1:0]             thrust_r,
  output logic [qxwm_pkg::MOTOR_W-1:0]             react_r
);

  logic [14:0] clamp_c;
  logic [37:0] thr_prod;
  logic [37:0] rea_prod;
  logic [37:0] thr_rnd;
  logic [37:0] rea_rnd;

  always_comb begin
    if (!drive_enable || motor_cmd[15]) begin
      clamp_c = '0;
    end else if (motor_cmd[14:0] > 15'(qxwm_pkg::CMD_ONE)) begin
      clamp_c = 15'(qxwm_pkg::CMD_ONE);
    end else begin
      clamp_c = motor_cmd[14:0];
    end
  end

  // The scaled value never exceeds the register value, so 24 bits hold it.
  assign thr_prod = 38'(max_thrust) * 38'(clamp_c);
  assign rea_prod = 38'(max_reaction_torque) * 38'(clamp_c);
  assign thr_rnd  = thr_prod + 38'd8192;
  assign rea_rnd  = rea_prod + 38'd8192;

  always_ff @(posedge clk) begin
    if (pipe_en.s1) begin
      thrust_r <= thr_rnd[37:14];
      react_r  <= rea_rnd[37:14];
    end
  end

endmodule

`default_nettype wire

>>> src/qxwm_mix.sv
// ----------------------------------------------------------------------------
// qxwm_mix: X-style merge of the motor lanes
// Stage two sums the lanes into total thrust and roll, pitch and yaw; stage
// three scales roll and pitch by the arm factor and flips pitch and yaw to FLU.
// ----------------------------------------------------------------------------
`default_nettype none

module qxwm_mix (
  input  wire logic                                 clk,
  input  wire qxwm_pkg::pipe_en_t                   pipe_en,
  input  wire logic [qxwm_pkg::MOTOR_W-1:0]         thrust [qxwm_pkg::NUM_MOTORS],
  input  wire logic [qxwm_pkg::MOTOR_W-1:0]         react [qxwm_pkg::NUM_MOTORS],
  input  wire logic [qxwm_pkg::MOTOR_W-1:0]         arm_factor,
  output logic [qxwm_pkg::TOTAL_W-1:0]              total_r,
  output qxwm_pkg::word_t                           torque_r [3]
);

  logic signed [qxwm_pkg::MIX_W-1:0] t_s [qxwm_pkg::NUM_MOTORS];
  logic signed [qxwm_pkg::MIX_W-1:0] r_s [qxwm_pkg::NUM_MOTORS];

  logic [qxwm_pkg::TOTAL_W-1:0]      sum_total_r;
  logic signed [qxwm_pkg::MIX_W-1:0] roll_r;
  logic signed [qxwm_pkg::MIX_W-1:0] pitch_r;
  logic signed [qxwm_pkg::MIX_W-1:0] yaw_r;

  logic signed [24:0] arm_s;
  logic signed [51:0] roll_prod;
  logic signed [51:0] pitch_prod;
  logic signed [51:0] roll_q;
  logic signed [51:0] pitch_q;

  always_comb begin
    for (int i = 0; i < qxwm_pkg::NUM_MOTORS; i++) begin
      t_s[i] = $signed({3'b000, thrust[i]});
      r_s[i] = $signed({3'b000, react[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en.s2) begin
      sum_total_r <= qxwm_pkg::TOTAL_W'(thrust[0]) + qxwm_pkg::TOTAL_W'(thrust[1])
                   + qxwm_pkg::TOTAL_W'(thrust[2]) + qxwm_pkg::TOTAL_W'(thrust[3]);
      roll_r  <= -t_s[0] + t_s[1] + t_s[2] - t_s[3];
      pitch_r <= -t_s[0] + t_s[1] - t_s[2] + t_s[3];
      yaw_r   <= -r_s[0] - r_s[1] + r_s[2] + r_s[3];
    end
  end

  assign arm_s      = $signed({1'b0, arm_factor});
  assign roll_prod  = 52'(arm_s) * 52'(roll_r);
  assign pitch_prod = 52'(arm_s) * 52'(pitch_r);
  assign roll_q     = (roll_prod + 52'sd32768) >>> 16;
  assign pitch_q    = (pitch_prod + 52'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (pipe_en.s3) begin
      total_r     <= sum_total_r;
      torque_r[0] <= qxwm_pkg::sat32(64'(roll_q));
      torque_r[1] <= qxwm_pkg::sat32(-64'(pitch_q));
      torque_r[2] <= qxwm_pkg::sat32(-64'(yaw_r));
    end
  end

endmodule

`default_nettype wire

>>> src/qxwm_attitude.sv
// ----------------------------------------------------------------------------
// qxwm_attitude: rotation matrix from the attitude quaternion
// Builds the body to world matrix in Q.28 without normalization and rounds
// each entry to Q.24. Registered at stage three.
// ----------------------------------------------------------------------------
`default_nettype none

module qxwm_attitude (
  input  wire logic                                  clk,
  input  wire qxwm_pkg::pipe_en_t                    pipe_en,
  input  wire logic signed [qxwm_pkg::QUAT_W-1:0]    quat_w,
  input  wire logic signed [qxwm_pkg::QUAT_W-1:0]    quat_x,
  input  wire logic signed [qxwm_pkg::QUAT_W-1:0]    quat_y,
  input  wire logic signed [qxwm_pkg::QUAT_W-1:0]    quat_z,
  output qxwm_pkg::mat_elem_t                        mat_r [3][3]
);

  localparam logic signed [34:0] ONE_Q28 = 35'sd268435456;

  logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [34:0] raw [3][3];

  function automatic qxwm_pkg::mat_elem_t round_q24(input logic signed [34:0] v);
    logic signed [34:0] s;
    s = (v + 35'sd8) >>> 4;
    return s[qxwm_pkg::MAT_W-1:0];
  endfunction

  assign xx = 32'(quat_x) * 32'(quat_x);
  assign yy = 32'(quat_y) * 32'(quat_y);
  assign zz = 32'(quat_z) * 32'(quat_z);
  assign xy = 32'(quat_x) * 32'(quat_y);
  assign xz = 32'(quat_x) * 32'(quat_z);
  assign yz = 32'(quat_y) * 32'(quat_z);
  assign wx = 32'(quat_w) * 32'(quat_x);
  assign wy = 32'(quat_w) * 32'(quat_y);
  assign wz = 32'(quat_w) * 32'(quat_z);

  always_comb begin
    raw[0][0] = ONE_Q28 - ((35'(yy) + 35'(zz)) <<< 1);
    raw[0][1] = (35'(xy) - 35'(wz)) <<< 1;
    raw[0][2] = (35'(xz) + 35'(wy)) <<< 1;
    raw[1][0] = (35'(xy) + 35'(wz)) <<< 1;
    raw[1][1] = ONE_Q28 - ((35'(xx) + 35'(zz)) <<< 1);
    raw[1][2] = (35'(yz) - 35'(wx)) <<< 1;
    raw[2][0] = (35'(xz) - 35'(wy)) <<< 1;
    raw[2][1] = (35'(yz) + 35'(wx)) <<< 1;
    raw[2][2] = ONE_Q28 - ((35'(xx) + 35'(yy)) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (pipe_en.s3) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mat_r[i][j] <= round_q24(raw[i][j]);
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> src/qxwm_rotate.sv
// ----------------------------------------------------------------------------
// qxwm_rotate: world-frame rotation and drag
// Stage four forms the matrix-vector products; stage five sums and rounds
// them, subtracts drag from the force and saturates into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qxwm_rotate (
  input  wire logic                                  clk,
  input  wire qxwm_pkg::pipe_en_t                    pipe_en,
  input  wire qxwm_pkg::mat_elem_t                   mat [3][3],
  input  wire logic [qxwm_pkg::TOTAL_W-1:0]          total,
  input  wire qxwm_pkg::word_t                       torque [3],
  input  wire logic signed [qxwm_pkg::DRAG_W-1:0]    drag [3],
  output qxwm_pkg::word_t                            force_out_r [3],
  output qxwm_pkg::word_t                            torque_out_r [3]
);

  logic signed [61:0]                 tprod_r [3][3];
  logic signed [56:0]                 fprod_r [3];
  logic signed [qxwm_pkg::DRAG_W-1:0] drag_r [3];

  logic signed [63:0] tsum [3];
  logic signed [63:0] fsum [3];
  logic signed [63:0] tw [3];
  logic signed [63:0] fw [3];

  // Body force is (0, 0, total), so only the third column meets the force.
  always_ff @(posedge clk) begin
    if (pipe_en.s4) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          tprod_r[i][j] <= 62'(mat[i][j]) * 62'(torque[j]);
        end
        fprod_r[i] <= 57'(mat[i][2]) * 57'($signed({1'b0, total}));
        drag_r[i]  <= drag[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tsum[i] = 64'(tprod_r[i][0]) + 64'(tprod_r[i][1]) + 64'(tprod_r[i][2])
              + 64'sd8388608;
      tw[i]   = tsum[i] >>> 24;
      fsum[i] = 64'(fprod_r[i]) + 64'sd8388608;
      fw[i]   = (fsum[i] >>> 24) - 64'(drag_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en.s5) begin
      for (int i = 0; i < 3; i++) begin
        torque_out_r[i] <= qxwm_pkg::sat32(tw[i]);
        force_out_r[i]  <= qxwm_pkg::sat32(fw[i]);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/quad_x_wrench_mixer_core.sv
// ----------------------------------------------------------------------------
// quad_x_wrench_mixer_core: X quadrotor motor mixer and world wrench
// Four motor lanes scale the commands, a merge stage mixes them into thrust
// and body torque, and the rotation stage turns force and torque into the
// world frame and removes linear drag.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Payload
//  in_      slave      tvalid / tready    tdata 200 bits, tuser 1 bit
//  out_     master     tvalid / tready    tdata 192 bits
//  cfg_     slave      valid / ready      index 8 bits, data 24 bits
//
//  One request per cycle in and out while out_tready is high; each request
//  passes lane scaling, lane merge, arm scaling and matrix build, matrix
//  products, then final sum, drag and saturation. A stage holds only while
//  the next one is full and stalled, so a waiting result stalls in_tready
//  only once every stage is full. Reset clears the valid bits and loads the
//  register defaults; cfg_ready is always high.
//
`default_nettype none

module quad_x_wrench_mixer_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  // in_tdata, from bit 0: motor_cmd_0, motor_cmd_1, motor_cmd_2, motor_cmd_3,
  // quat_w, quat_x, quat_y, quat_z, vel_x, vel_y, vel_z
  input  wire logic [199:0]  in_tdata,
  // in_tuser: drive_enable
  input  wire logic [0:0]    in_tuser,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // out_tdata, from bit 0: force_x, force_y, force_z, moment_x, moment_y, moment_z
  output logic [191:0]       out_tdata,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [qxwm_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [qxwm_pkg::CFG_W-1:0] cfg_data
);

  logic [qxwm_pkg::CFG_W-1:0] max_thrust_r;
  logic [qxwm_pkg::CFG_W-1:0] max_react_r;
  logic [qxwm_pkg::CFG_W-1:0] arm_length_r;
  logic [qxwm_pkg::CFG_W-1:0] drag_coeff_r;
  logic [qxwm_pkg::MOTOR_W-1:0] arm_factor_r;

  logic [4:0] vld_r;
  logic [4:0] vld_nxt;
  logic [4:0] rdy;
  qxwm_pkg::pipe_en_t pipe_en;

  logic signed [qxwm_pkg::CMD_W-1:0]  motor_cmd [qxwm_pkg::NUM_MOTORS];
  logic [qxwm_pkg::MOTOR_W-1:0]       thrust_s1 [qxwm_pkg::NUM_MOTORS];
  logic [qxwm_pkg::MOTOR_W-1:0]       react_s1 [qxwm_pkg::NUM_MOTORS];

  logic signed [qxwm_pkg::VEL_W-1:0]  vel [3];
  logic signed [48:0]                 drag_prod [3];
  logic signed [48:0]                 drag_rnd [3];
  logic signed [qxwm_pkg::DRAG_W-1:0] drag_s1_r [3];
  logic signed [qxwm_pkg::DRAG_W-1:0] drag_s2_r [3];
  logic signed [qxwm_pkg::DRAG_W-1:0] drag_s3_r [3];

  logic [63:0] quat_s1_r;
  logic [63:0] quat_s2_r;

  logic [39:0] arm_prod;
  logic [qxwm_pkg::TOTAL_W-1:0] total_s3;
  qxwm_pkg::word_t              torque_s3 [3];
  qxwm_pkg::mat_elem_t          mat_s3 [3][3];
  qxwm_pkg::word_t              force_out [3];
  qxwm_pkg::word_t              torque_out [3];

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_thrust_r <= qxwm_pkg::RST_MAX_THRUST;
      max_react_r  <= qxwm_pkg::RST_MAX_REACT;
      arm_length_r <= qxwm_pkg::RST_ARM_LENGTH;
      drag_coeff_r <= qxwm_pkg::RST_DRAG_COEFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        qxwm_pkg::REG_MAX_THRUST: max_thrust_r <= cfg_data;
        qxwm_pkg::REG_MAX_REACT:  max_react_r  <= cfg_data;
        qxwm_pkg::REG_ARM_LENGTH: arm_length_r <= cfg_data;
        qxwm_pkg::REG_DRAG_COEFF: drag_coeff_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Arm factor is registered from the arm length in the cycle after it; the user
  // must write configuration only while the pipeline is empty; the block does not enforce it.
  assign arm_prod = 40'(arm_length_r) * 40'(qxwm_pkg::SQRT_HALF_Q16) + 40'd32768;

  always_ff @(posedge clk) begin
    arm_factor_r <= arm_prod[39:16];
  end

  // Pipeline control: a stage loads when it is empty or its content moves on.
  always_comb begin
    rdy[4] = !vld_r[4] || out_tready;
    rdy[3] = !vld_r[3] || rdy[4];
    rdy[2] = !vld_r[2] || rdy[3];
    rdy[1] = !vld_r[1] || rdy[2];
    rdy[0] = !vld_r[0] || rdy[1];
    vld_nxt[0] = rdy[0] ? in_tvalid : vld_r[0];
    vld_nxt[1] = rdy[1] ? vld_r[0]  : vld_r[1];
    vld_nxt[2] = rdy[2] ? vld_r[1]  : vld_r[2];
    vld_nxt[3] = rdy[3] ? vld_r[2]  : vld_r[3];
    vld_nxt[4] = rdy[4] ? vld_r[3]  : vld_r[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign pipe_en.s1 = rdy[0];
  assign pipe_en.s2 = rdy[1];
  assign pipe_en.s3 = rdy[2];
  assign pipe_en.s4 = rdy[3];
  assign pipe_en.s5 = rdy[4];

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[4];

  // Motor lanes.
  genvar gi;
  generate
    for (gi = 0; gi < qxwm_pkg::NUM_MOTORS; gi++) begin : g_lane
      assign motor_cmd[gi] = $signed(in_tdata[gi*qxwm_pkg::CMD_W +: qxwm_pkg::CMD_W]);

      qxwm_lane u_lane (
        .clk                 (clk),
        .pipe_en             (pipe_en),
        .motor_cmd           (motor_cmd[gi]),
        .drive_enable        (in_tuser[0]),
        .max_thrust          (max_thrust_r),
        .max_reaction_torque (max_react_r),
        .thrust_r            (thrust_s1[gi]),
        .react_r             (react_s1[gi])
      );
    end
  endgenerate

  // Drag is formed at stage one and carried along to the final subtraction.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vel[i]       = $signed(in_tdata[128 + i*qxwm_pkg::VEL_W +: qxwm_pkg::VEL_W]);
      drag_prod[i] = 49'($signed({1'b0, drag_coeff_r})) * 49'(vel[i]);
      drag_rnd[i]  = (drag_prod[i] + 49'sd128) >>> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en.s1) begin
      quat_s1_r <= in_tdata[127:64];
      for (int i = 0; i < 3; i++) begin
        drag_s1_r[i] <= drag_rnd[i][qxwm_pkg::DRAG_W-1:0];
      end
    end
    if (pipe_en.s2) begin
      quat_s2_r <= quat_s1_r;
      drag_s2_r <= drag_s1_r;
    end
    if (pipe_en.s3) begin
      drag_s3_r <= drag_s2_r;
    end
  end

  qxwm_mix u_mix (
    .clk        (clk),
    .pipe_en    (pipe_en),
    .thrust     (thrust_s1),
    .react      (react_s1),
    .arm_factor (arm_factor_r),
    .total_r    (total_s3),
    .torque_r   (torque_s3)
  );

  qxwm_attitude u_attitude (
    .clk     (clk),
    .pipe_en (pipe_en),
    .quat_w  ($signed(quat_s2_r[15:0])),
    .quat_x  ($signed(quat_s2_r[31:16])),
    .quat_y  ($signed(quat_s2_r[47:32])),
    .quat_z  ($signed(quat_s2_r[63:48])),
    .mat_r   (mat_s3)
  );

  qxwm_rotate u_rotate (
    .clk          (clk),
    .pipe_en      (pipe_en),
    .mat          (mat_s3),
    .total        (total_s3),
    .torque       (torque_s3),
    .drag         (drag_s3_r),
    .force_out_r  (force_out),
    .torque_out_r (torque_out)
  );

  assign out_tdata = {torque_out[2], torque_out[1], torque_out[0],
                      force_out[2], force_out[1], force_out[0]};

endmodule

`default_nettype wire

>>> tb/quad_x_wrench_mixer_core_tb.sv
// ----------------------------------------------------------------------------
// quad_x_wrench_mixer_core_tb: self-checking bench for the quad X wrench mixer
// Drives motor commands, attitude and velocity into the mixer and checks every
// world force and torque against an in-bench fixed-point predictor. The run
// covers corner values, register extremes, random traffic under several idle
// and stall mixes, and a long output hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module quad_x_wrench_mixer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qxwm_pkg::*;

  localparam int PIPE_LATENCY = 5;
  localparam int HOLD_CYCLES  = 200;
  localparam int RUN_LIMIT_NS = 400000;
  localparam logic [IDX_W-1:0] FIRST_UNUSED_REG = REG_DRAG_COEFF + 8'd1;
  localparam logic [15:0] QUAT_ONE     = 16'h4000;
  localparam logic [15:0] QUAT_NEG_ONE = 16'hC000;

  // Packed so that the low 200 bits line up with in_tdata.
  typedef struct packed {
    logic             drive_enable;
    logic [2:0][23:0] vel;
    logic [15:0]      quat_z;
    logic [15:0]      quat_y;
    logic [15:0]      quat_x;
    logic [15:0]      quat_w;
    logic [3:0][15:0] cmd;
  } mixer_req_t;

  // Packed to line up with out_tdata.
  typedef struct packed {
    logic [2:0][31:0] world_torque;
    logic [2:0][31:0] world_force;
  } wrench_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  // in_tdata, from bit 0: motor_cmd_0..3, quat_w, quat_x, quat_y, quat_z,
  // vel_x, vel_y, vel_z
  logic [199:0]        in_tdata   = '0;
  // in_tuser: drive_enable
  logic [0:0]          in_tuser   = '0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  // out_tdata, from bit 0: force_x, force_y, force_z, moment_x, moment_y,
  // moment_z
  logic [191:0]        out_tdata;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index  = '0;
  logic [CFG_W-1:0]    cfg_data   = '0;

  // Register values as the block should hold them.
  logic [CFG_W-1:0] thrust_reg = RST_MAX_THRUST;
  logic [CFG_W-1:0] react_reg  = RST_MAX_REACT;
  logic [CFG_W-1:0] arm_reg    = RST_ARM_LENGTH;
  logic [CFG_W-1:0] drag_reg   = RST_DRAG_COEFF;

  wrench_t expected_wrench_q[$];
  int      error_count    = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  logic    hold_kick      = 1'b0;
  logic    hold_seen      = 1'b0;
  int      hold_left      = 0;

  quad_x_wrench_mixer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  // Add half an LSB, then floor.
  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_word(input longint v);
    longint res;
    res = v;
    if (v > 64'sd2147483647) begin
      res = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      res = -64'sd2147483648;
    end
    return res;
  endfunction

  function automatic wrench_t predict_wrench(input mixer_req_t req);
    longint  cmd, total, arm_scaled, roll, pitch, yaw, drag;
    longint  qw, qx, qy, qz;
    longint  thrust [4];
    longint  react [4];
    longint  body_force [3];
    longint  body_torque [3];
    longint  rot [3][3];
    longint  world_f, world_t;
    wrench_t res;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      cmd = longint'($signed(req.cmd[i]));
      if (!req.drive_enable || cmd < 0) cmd = 0;
      if (cmd > longint'(CMD_ONE)) cmd = longint'(CMD_ONE);
      thrust[i] = round_shift(longint'(thrust_reg) * cmd, 14);
      react[i]  = round_shift(longint'(react_reg) * cmd, 14);
    end
    total      = thrust[0] + thrust[1] + thrust[2] + thrust[3];
    arm_scaled = round_shift(longint'(arm_reg) * longint'(SQRT_HALF_Q16), 16);
    roll  = -thrust[0] + thrust[1] + thrust[2] - thrust[3];
    pitch = -thrust[0] + thrust[1] - thrust[2] + thrust[3];
    yaw   = -react[0] - react[1] + react[2] + react[3];
    // Pitch and yaw change sign going from FRD to FLU.
    body_torque[0] = clamp_word(round_shift(arm_scaled * roll, 16));
    body_torque[1] = clamp_word(-round_shift(arm_scaled * pitch, 16));
    body_torque[2] = clamp_word(-yaw);
    body_force[0]  = 0;
    body_force[1]  = 0;
    body_force[2]  = total;

    qw = longint'($signed(req.quat_w));
    qx = longint'($signed(req.quat_x));
    qy = longint'($signed(req.quat_y));
    qz = longint'($signed(req.quat_z));
    // Entries in Q.28, no normalization, then rounded to Q.24.
    rot[0][0] = (longint'(1) <<< 28) - 2 * (qy * qy + qz * qz);
    rot[0][1] = 2 * (qx * qy - qw * qz);
    rot[0][2] = 2 * (qx * qz + qw * qy);
    rot[1][0] = 2 * (qx * qy + qw * qz);
    rot[1][1] = (longint'(1) <<< 28) - 2 * (qx * qx + qz * qz);
    rot[1][2] = 2 * (qy * qz - qw * qx);
    rot[2][0] = 2 * (qx * qz - qw * qy);
    rot[2][1] = 2 * (qy * qz + qw * qx);
    rot[2][2] = (longint'(1) <<< 28) - 2 * (qx * qx + qy * qy);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rot[i][j] = round_shift(rot[i][j], 4);
      end
    end

    for (int i = 0; i < 3; i++) begin
      world_f = round_shift(rot[i][0] * body_force[0] + rot[i][1] * body_force[1]
                            + rot[i][2] * body_force[2], 24);
      world_t = round_shift(rot[i][0] * body_torque[0] + rot[i][1] * body_torque[1]
                            + rot[i][2] * body_torque[2], 24);
      drag = round_shift(longint'(drag_reg) * longint'($signed(req.vel[i])), 8);
      res.world_force[i]  = 32'(clamp_word(world_f - drag));
      res.world_torque[i] = 32'(clamp_word(world_t));
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic mixer_req_t make_request(input int c0, input int c1, input int c2,
                                              input int c3, input bit en, input int qw,
                                              input int qx, input int qy, input int qz,
                                              input int vx, input int vy, input int vz);
    mixer_req_t r;
    r.cmd[0] = 16'(c0);
    r.cmd[1] = 16'(c1);
    r.cmd[2] = 16'(c2);
    r.cmd[3] = 16'(c3);
    r.drive_enable = en;
    r.quat_w = 16'(qw);
    r.quat_x = 16'(qx);
    r.quat_y = 16'(qy);
    r.quat_z = 16'(qz);
    r.vel[0] = 24'(vx);
    r.vel[1] = 24'(vy);
    r.vel[2] = 24'(vz);
    return r;
  endfunction

  function automatic logic [15:0] quat_component(input int span);
    return 16'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic mixer_req_t random_request();
    mixer_req_t  r;
    int          pick;
    logic [15:0] axis;
    r = '0;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      pick = $urandom_range(9);
      if (pick < 6) r.cmd[i] = 16'($urandom_range(CMD_ONE));
      else if (pick == 6) r.cmd[i] = 16'($urandom_range(32767, CMD_ONE + 1));
      else if (pick == 7) r.cmd[i] = 16'h8000 | 16'($urandom);
      else r.cmd[i] = 16'($urandom);
    end
    r.drive_enable = ($urandom_range(99) < 88);
    pick = $urandom_range(9);
    if (pick < 6) begin
      r.quat_w = quat_component(16384);
      r.quat_x = quat_component(16384);
      r.quat_y = quat_component(16384);
      r.quat_z = quat_component(16384);
    end else if (pick < 8) begin
      // Half turns and identity about a single axis.
      axis = ($urandom_range(1) != 0) ? QUAT_ONE : QUAT_NEG_ONE;
      case ($urandom_range(3))
        0: r.quat_w = axis;
        1: r.quat_x = axis;
        2: r.quat_y = axis;
        default: r.quat_z = axis;
      endcase
    end else begin
      r.quat_w = quat_component(4096);
      r.quat_x = quat_component(4096);
      r.quat_y = quat_component(4096);
      r.quat_z = quat_component(4096);
    end
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(9) < 7) r.vel[i] = 24'(int'($urandom_range(8192)) - 4096);
      else r.vel[i] = 24'($urandom);
    end
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] random_setting(input logic [CFG_W-1:0] rst_value);
    logic [CFG_W-1:0] value;
    case ($urandom_range(3))
      0: value = rst_value;
      1: value = 24'($urandom);
      2: value = 24'($urandom_range(2 * int'(rst_value)));
      default: value = ($urandom_range(1) != 0) ? '1 : '0;
    endcase
    return value;
  endfunction

  task automatic send_request(input mixer_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= req[199:0];
    in_tuser  <= req.drive_enable;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_wrench_q.push_back(predict_wrench(req));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_wrench_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 3) @(posedge clk);
  endtask

  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MAX_THRUST: thrust_reg = value;
      REG_MAX_REACT:  react_reg  = value;
      REG_ARM_LENGTH: arm_reg    = value;
      REG_DRAG_COEFF: drag_reg   = value;
      default: ;
    endcase
  endtask

  // Writes all four registers, then a stray index that must change nothing.
  task automatic apply_settings(input logic [CFG_W-1:0] thrust, input logic [CFG_W-1:0] react,
                                input logic [CFG_W-1:0] arm, input logic [CFG_W-1:0] drag);
    write_register(REG_MAX_THRUST, thrust);
    write_register(REG_MAX_REACT, react);
    write_register(REG_ARM_LENGTH, arm);
    write_register(REG_DRAG_COEFF, drag);
    write_register(8'($urandom_range(255, FIRST_UNUSED_REG)), 24'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    wrench_t got;
    wrench_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_wrench_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_wrench_q.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got.world_force[i] !== want.world_force[i])
            report_mismatch($sformatf("force axis %0d got %0d expected %0d", i,
                                      $signed(got.world_force[i]),
                                      $signed(want.world_force[i])));
          if (got.world_torque[i] !== want.world_torque[i])
            report_mismatch($sformatf("torque axis %0d got %0d expected %0d", i,
                                      $signed(got.world_torque[i]),
                                      $signed(want.world_torque[i])));
        end
      end
    end
  end

  // Output ready: random stalls, or a long hold-off when the test asks.
  always @(posedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen  <= hold_kick;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed_corners();
    send_request(make_request(0, 0, 0, 0, 1, 16384, 0, 0, 0, 0, 0, 0));
    send_request(make_request(16384, 16384, 16384, 16384, 1, 16384, 0, 0, 0, 0, 0, 0));
    send_request(make_request(32767, 32767, 32767, 32767, 1, 16384, 0, 0, 0, 256, -256, 512));
    send_request(make_request(-32768, -1, -16384, -32768, 1, 16384, 0, 0, 0, 0, 0, 0));
    send_request(make_request(16385, 16383, 1, -1, 1, 16384, 0, 0, 0, 0, 0, 0));
    // Drive disabled: motors are off but drag still acts.
    send_request(make_request(16384, 16384, 16384, 16384, 0, 16384, 0, 0, 0, 2560, -2560, 1280));
    send_request(make_request(0, 16384, 16384, 0, 1, 16384, 0, 0, 0, 0, 0, 0));
    send_request(make_request(0, 16384, 0, 16384, 1, 16384, 0, 0, 0, 0, 0, 0));
    send_request(make_request(0, 0, 16384, 16384, 1, 16384, 0, 0, 0, 0, 0, 0));
    send_request(make_request(8192, 12000, 4000, 16384, 1, -16384, 0, 0, 0, 100, 0, 0));
    send_request(make_request(8192, 12000, 4000, 16384, 1, 0, 16384, 0, 0, 0, 100, 0));
    send_request(make_request(16384, 0, 9000, 3000, 1, 0, 0, 16384, 0, 0, 0, 100));
    send_request(make_request(3000, 16384, 0, 9000, 1, 0, 0, 0, -16384, 0, 0, 0));
    send_request(make_request(16384, -32768, 32767, 8192, 1, 11585, 11585, 0, 0, 0, 0, 0));
    // Quaternions far from unit length scale the result.
    send_request(make_request(16384, 8000, 16384, 2000, 1, 16384, 16384, 16384, 16384, 0, 0, 0));
    send_request(make_request(16384, 8000, 16384, 2000, 1, -16384, -16384, -16384, -16384,
                              0, 0, 0));
    send_request(make_request(16384, 16384, 16384, 16384, 1, 0, 0, 0, 0, 512, 512, 512));
    send_request(make_request(16384, 0, 16384, 0, 1, 16384, 0, 0, 0,
                              8388607, -8388608, 8388607));
    send_request(make_request(0, 16384, 0, 16384, 1, 16384, 0, 0, 0,
                              -8388608, 8388607, -8388608));
  endtask

  task automatic test_register_extremes();
    wait_drained();
    apply_settings('1, '1, '1, '1);
    send_request(make_request(16384, 16384, 16384, 16384, 1, 16384, 16384, 16384, 16384,
                              0, 0, 0));
    send_request(make_request(0, 16384, 16384, 0, 1, 16384, 0, 0, 0, 0, 0, 0));
    send_request(make_request(16384, 0, 0, 16384, 1, 16384, 0, 0, 0, 0, 0, 0));
    send_request(make_request(0, 0, 16384, 16384, 1, 16384, 0, 0, 0, 0, 0, 0));
    send_request(make_request(0, 16384, 16384, 0, 1, 16384, 16384, 16384, 16384, 0, 0, 0));
    send_request(make_request(0, 0, 0, 0, 0, 16384, 0, 0, 0, 8388607, -8388608, 8388607));
    wait_drained();
    apply_settings('0, '0, '0, '0);
    send_request(make_request(16384, 16384, 0, 16384, 1, 16384, 0, 0, 0,
                              -8388608, 8388607, -8388608));
    send_request(make_request(32767, 0, 16384, 0, 1, 11585, 0, 11585, 0, 8388607, 0, 0));
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    wait_drained();
    apply_settings(random_setting(RST_MAX_THRUST), random_setting(RST_MAX_REACT),
                   random_setting(RST_ARM_LENGTH), random_setting(RST_DRAG_COEFF));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_request(random_request());
  endtask

  task automatic test_backpressure();
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // The output holds off far longer than the pipeline is deep, so the
    // input has to stall while requests keep coming.
    hold_kick <= ~hold_kick;
    repeat (60) send_request(random_request());
    wait_drained();
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    repeat (40) send_request(random_request());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    test_register_extremes();
    test_random_traffic(0, 0, 370);
    test_random_traffic(49, 0, 370);
    test_random_traffic(0, 49, 370);
    test_random_traffic(14, 14, 370);
    test_backpressure();
    wait_drained();
    if (error_count == 0) begin
      $display("quad_x_wrench_mixer_core_tb passed");
    end else begin
      $display("quad_x_wrench_mixer_core_tb failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("quad_x_wrench_mixer_core_tb failed");
    $finish;
  end

endmodule
